/* rtl/core/rrr_pkg.sv */
package rrr_pkg;

  // ring geometry
  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int ID_W   = 16;

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  // item kinds
  localparam logic [1:0] KIND_JOIN = 2'd0;
  localparam logic [1:0] KIND_TURN = 2'd1;
  localparam logic [1:0] KIND_ELIM = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // requests from the engine to the id and link stores
  typedef struct packed {
    logic  id_we;
    slot_t id_addr;
    id_t   id_data;
    logic  link_we;
    slot_t link_addr;
    slot_t link_data;
    logic  rd_en;
    slot_t rd_addr;
  } mem_req_t;

  // one finished result word
  typedef struct packed {
    logic [1:0] status;
    logic       cur_valid;
    id_t        cur_id;
    cnt_t       count;
  } res_t;

endpackage

/* rtl/core/round_robin_ring_with_removal.sv */
// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------------------
// input    | in_valid / in_ready    | kind, member_id
// output   | out_valid / out_ready  | status, current_valid, current_member,
//          |                        | member_count
//
// one word in the engine at a time; it goes idle once its result enters the output
// register. join: S_JOIN, S_LINK_TAIL; end turn: S_TURN_RD, S_TURN_WB; eliminate:
// S_ELIM_START, one S_ELIM_CHK per link walked (to the match, or count if not found);
// empty ring, full store, unused kind: none; then all S_RDCUR, S_FINISH. in_ready comes
// back with out_valid. a stalled output holds the engine in S_FINISH until the register
// frees; reset clears pointers, count and used bits; stores are written before use.
module round_robin_ring_with_removal
  import rrr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       kind,
  input  logic [ID_W-1:0]  member_id,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic             current_valid,
  output logic [ID_W-1:0]  current_member,
  output logic [CNT_W-1:0] member_count
);

  logic [SLOTS-1:0] used;
  logic             free_found;
  slot_t            free_slot;
  mem_req_t         mem_req;
  id_t              ids_rdata;
  slot_t            link_rdata;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  rrr_free_pick u_free (
    .used  (used),
    .found (free_found),
    .slot  (free_slot)
  );

  rrr_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_ids (
    .clk   (clk),
    .we    (mem_req.id_we),
    .waddr (mem_req.id_addr),
    .wdata (mem_req.id_data),
    .re    (mem_req.rd_en),
    .raddr (mem_req.rd_addr),
    .rdata (ids_rdata)
  );

  rrr_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_links (
    .clk   (clk),
    .we    (mem_req.link_we),
    .waddr (mem_req.link_addr),
    .wdata (mem_req.link_data),
    .re    (mem_req.rd_en),
    .raddr (mem_req.rd_addr),
    .rdata (link_rdata)
  );

  rrr_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .member_id  (member_id),
    .used       (used),
    .free_found (free_found),
    .free_slot  (free_slot),
    .mem_req    (mem_req),
    .ids_rdata  (ids_rdata),
    .link_rdata (link_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status         <= res.status;
      current_valid  <= res.cur_valid;
      current_member <= res.cur_id;
      member_count   <= res.count;
    end
  end

endmodule

/* rtl/core/rrr_ram.sv */
module rrr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/rrr_free_pick.sv */
module rrr_free_pick
  import rrr_pkg::*;
(
  input  logic [SLOTS-1:0] used,
  output logic             found,
  output slot_t            slot
);

  // lowest unused slot wins
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        found = 1'b1;
        slot  = SLOT_W'(i);
      end
    end
  end

endmodule

/* rtl/core/rrr_engine.sv */
module rrr_engine
  import rrr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       kind,
  input  id_t              member_id,
  output logic [SLOTS-1:0] used,
  input  logic             free_found,
  input  slot_t            free_slot,
  output mem_req_t         mem_req,
  input  id_t              ids_rdata,
  input  slot_t            link_rdata,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_JOIN,
    S_LINK_TAIL,
    S_TURN_RD,
    S_TURN_WB,
    S_ELIM_START,
    S_ELIM_CHK,
    S_RDCUR,
    S_FINISH
  } state_t;

  state_t     state;
  id_t        id_q;
  slot_t      fresh;
  slot_t      head;
  slot_t      tail;
  slot_t      turn;
  cnt_t       count;
  slot_t      walk;
  slot_t      prev;
  cnt_t       steps;
  logic [1:0] status_q;

  logic id_match;
  cnt_t steps_next;

  assign id_match   = (ids_rdata == id_q);
  assign steps_next = steps + 1'b1;

  // sequencer and ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      used     <= '0;
      head     <= '0;
      tail     <= '0;
      turn     <= '0;
      count    <= '0;
      status_q <= ST_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            id_q     <= member_id;
            status_q <= ST_OK;
            unique case (kind)
              KIND_JOIN: begin
                if (count >= SLOTS_CNT || !free_found) begin
                  status_q <= ST_FULL;
                  state    <= S_RDCUR;
                end else begin
                  fresh <= free_slot;
                  state <= S_JOIN;
                end
              end
              KIND_TURN: begin
                if (count == '0) begin
                  status_q <= ST_EMPTY;
                  state    <= S_RDCUR;
                end else begin
                  state <= S_TURN_RD;
                end
              end
              KIND_ELIM: begin
                if (count == '0) begin
                  status_q <= ST_EMPTY;
                  state    <= S_RDCUR;
                end else begin
                  walk  <= head;
                  prev  <= tail;
                  steps <= '0;
                  state <= S_ELIM_START;
                end
              end
              default: begin
                state <= S_RDCUR;
              end
            endcase
          end
        end
        S_JOIN: begin
          used[fresh] <= 1'b1;
          state       <= S_LINK_TAIL;
        end
        S_LINK_TAIL: begin
          if (count == '0) begin
            head <= fresh;
          end
          tail  <= fresh;
          turn  <= fresh;
          count <= count + 1'b1;
          state <= S_RDCUR;
        end
        S_TURN_RD: begin
          state <= S_TURN_WB;
        end
        S_TURN_WB: begin
          turn  <= link_rdata;
          state <= S_RDCUR;
        end
        S_ELIM_START: begin
          state <= S_ELIM_CHK;
        end
        S_ELIM_CHK: begin
          if (id_match) begin
            // unlink the matching member
            used[walk] <= 1'b0;
            if (count == cnt_t'(1)) begin
              head  <= '0;
              tail  <= '0;
              turn  <= '0;
              count <= '0;
            end else begin
              if (walk == head) begin
                head <= link_rdata;
              end
              if (walk == tail) begin
                tail <= prev;
              end
              if (walk == turn) begin
                turn <= link_rdata;
              end
              count <= count - 1'b1;
            end
            state <= S_RDCUR;
          end else if (steps_next >= count) begin
            status_q <= ST_NOT_FOUND;
            state    <= S_RDCUR;
          end else begin
            steps <= steps_next;
            prev  <= walk;
            walk  <= link_rdata;
          end
        end
        S_RDCUR: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // store accesses per state
  always_comb begin
    mem_req = '0;
    unique case (state)
      S_JOIN: begin
        mem_req.id_we     = 1'b1;
        mem_req.id_addr   = fresh;
        mem_req.id_data   = id_q;
        mem_req.link_we   = 1'b1;
        mem_req.link_addr = fresh;
        mem_req.link_data = (count == '0) ? fresh : head;
      end
      S_LINK_TAIL: begin
        mem_req.link_we   = (count != '0);
        mem_req.link_addr = tail;
        mem_req.link_data = fresh;
      end
      S_TURN_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = turn;
      end
      S_ELIM_START: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = walk;
      end
      S_ELIM_CHK: begin
        // follow the link straight from the read data
        mem_req.rd_en     = 1'b1;
        mem_req.rd_addr   = link_rdata;
        mem_req.link_we   = id_match && (count != cnt_t'(1));
        mem_req.link_addr = prev;
        mem_req.link_data = link_rdata;
      end
      S_RDCUR: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = turn;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  // handshake and result word
  assign in_ready      = (state == S_IDLE);
  assign res_valid     = (state == S_FINISH);
  assign res.status    = status_q;
  assign res.cur_valid = (count != '0);
  assign res.cur_id    = (count != '0) ? ids_rdata : '0;
  assign res.count     = count;

endmodule

/* rtl/core/rrr_checker.sv */
module rrr_checker
  import rrr_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [1:0]       kind,
  input logic [ID_W-1:0]  member_id,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       status,
  input logic             current_valid,
  input logic [ID_W-1:0]  current_member,
  input logic [CNT_W-1:0] member_count
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)
      && $stable(current_member) && $stable(member_count))
    else $error("result word changed while stalled");

  // current valid tracks a nonzero count
  a_cur_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (current_valid == (member_count != '0)) && (member_count <= SLOTS_CNT))
    else $error("current_valid disagrees with member_count");

  // an empty ring shows no current member
  a_empty_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && !current_valid |-> current_member == '0)
    else $error("current_member set on an empty ring");

  // full only when every slot holds a member, empty only with none
  a_status_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != ST_FULL || member_count == SLOTS_CNT)
      && (status != ST_EMPTY || member_count == '0))
    else $error("status code inconsistent with member_count");

endmodule

bind round_robin_ring_with_removal rrr_checker u_rrr_checker (.*);

/* dv/round_robin_ring_with_removal_tb.sv */
`timescale 1ns / 100ps

module round_robin_ring_with_removal_tb;
  import rrr_pkg::*;

  // kind code the block ignores
  localparam logic [1:0] KIND_SPARE = 2'd3;
  // cycles with no word moving on either side before the run is called hung
  localparam int STALL_LIMIT = 4000;
  // settle time after the last result
  localparam int DRAIN_CYCLES = 40;

  logic            clk;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [1:0]      kind = KIND_JOIN;
  id_t             member_id = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [1:0]      status;
  logic            current_valid;
  id_t             current_member;
  cnt_t            member_count;

  // predicted ring state
  id_t   ring_id   [SLOTS];
  slot_t ring_link [SLOTS];
  logic  ring_busy [SLOTS];
  slot_t head_p;
  slot_t tail_p;
  slot_t turn_p;
  cnt_t  members;

  // expected reports, oldest first
  res_t ring_reports[$];

  int   err_cnt = 0;
  int   words_in = 0;
  int   words_out = 0;
  int   status_seen[4];
  int   full_ring_seen = 0;
  bit   calm = 1'b0;
  int   hold_left = 0;
  int   idle_cycles = 0;

  round_robin_ring_with_removal i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .member_id      (member_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .current_valid  (current_valid),
    .current_member (current_member),
    .member_count   (member_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // join at tail, lowest free slot
  function automatic logic [1:0] ring_join(id_t id);
    int s;
    slot_t fresh;
    if (members >= SLOTS_CNT) return ST_FULL;
    s = 0;
    while (s < SLOTS && ring_busy[s]) s++;
    if (s >= SLOTS) return ST_FULL;
    fresh = slot_t'(s);
    ring_id[fresh] = id;
    ring_busy[fresh] = 1'b1;
    if (members == 0) begin
      ring_link[fresh] = fresh;
      head_p = fresh;
    end else begin
      ring_link[fresh] = head_p;
      ring_link[tail_p] = fresh;
    end
    tail_p = fresh;
    turn_p = fresh;
    members++;
    return ST_OK;
  endfunction

  // remove first match counted from the head
  function automatic logic [1:0] ring_remove(id_t id);
    slot_t walk;
    slot_t prev;
    slot_t after;
    bit    hit;
    int    i;
    if (members == 0) return ST_EMPTY;
    walk = head_p;
    prev = tail_p;
    hit = 1'b0;
    for (i = 0; i < members; i++) begin
      if (ring_id[walk] == id) begin
        hit = 1'b1;
        break;
      end
      prev = walk;
      walk = ring_link[walk];
    end
    if (!hit) return ST_NOT_FOUND;
    after = ring_link[walk];
    ring_busy[walk] = 1'b0;
    if (members == 1) begin
      head_p = '0;
      tail_p = '0;
      turn_p = '0;
      members = '0;
      return ST_OK;
    end
    ring_link[prev] = after;
    if (walk == head_p) head_p = after;
    if (walk == tail_p) tail_p = prev;
    if (walk == turn_p) turn_p = after;
    members--;
    return ST_OK;
  endfunction

  // apply one word to the predicted ring and build its report
  function automatic res_t ring_apply(logic [1:0] k, id_t id);
    res_t rep;
    logic [1:0] st;
    st = ST_OK;
    case (k)
      KIND_JOIN: st = ring_join(id);
      KIND_TURN: begin
        if (members == 0) st = ST_EMPTY;
        else turn_p = ring_link[turn_p];
      end
      KIND_ELIM: st = ring_remove(id);
      default: ;
    endcase
    rep.status    = st;
    rep.cur_valid = (members != 0);
    rep.cur_id    = (members != 0) ? ring_id[turn_p] : '0;
    rep.count     = members;
    return rep;
  endfunction

  // id of some member now in the ring, random if the ring is empty
  function automatic id_t present_id();
    int picks[$];
    int s;
    for (s = 0; s < SLOTS; s++)
      if (ring_busy[s]) picks.push_back(s);
    if (picks.size() == 0) return id_t'($urandom);
    return ring_id[picks[$urandom_range(0, picks.size() - 1)]];
  endfunction

  // small id set so duplicates and hits are frequent
  function automatic id_t pool_id();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'h00F0 + id_t'($urandom_range(0, 5));
    endcase
  endfunction

  // send one word and record its expected report once accepted
  task automatic send_word(logic [1:0] k, id_t id);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    member_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ring_reports.push_back(ring_apply(k, id));
    words_in++;
  endtask

  // empty ring, single member, ignored kind, not found
  task automatic test_empty_ring();
    send_word(KIND_TURN, 16'h0000);
    send_word(KIND_ELIM, 16'h0042);
    send_word(KIND_SPARE, 16'hFFFF);
    send_word(KIND_JOIN, 16'h0000);
    send_word(KIND_TURN, 16'hFFFF);
    send_word(KIND_ELIM, 16'hBEEF);
    send_word(KIND_ELIM, 16'h0000);
    send_word(KIND_JOIN, 16'hFFFF);
    send_word(KIND_SPARE, 16'h0000);
    send_word(KIND_ELIM, 16'hFFFF);
  endtask

  // removal of head, tail, turn member and duplicates
  task automatic test_head_tail_turn();
    send_word(KIND_JOIN, 16'h1111);
    send_word(KIND_JOIN, 16'h2222);
    send_word(KIND_JOIN, 16'h3333);
    send_word(KIND_JOIN, 16'h2222);
    send_word(KIND_ELIM, 16'h2222);
    send_word(KIND_ELIM, 16'h1111);
    send_word(KIND_TURN, 16'h0000);
    send_word(KIND_ELIM, 16'h2222);
    send_word(KIND_JOIN, 16'h4444);
    send_word(KIND_ELIM, 16'h4444);
    send_word(KIND_ELIM, 16'h3333);
  endtask

  // fill the store, overflow, free two slots and rejoin them
  task automatic test_full_store();
    int i;
    i = 0;
    while (members < SLOTS_CNT) begin
      send_word(KIND_JOIN, 16'h0100 + id_t'(i));
      i++;
    end
    send_word(KIND_JOIN, 16'hDEAD);
    send_word(KIND_ELIM, ring_id[5]);
    send_word(KIND_ELIM, ring_id[2]);
    send_word(KIND_JOIN, 16'hA5A5);
    send_word(KIND_JOIN, 16'h5A5A);
    send_word(KIND_JOIN, 16'hC3C3);
  endtask

  // random traffic steered toward a fill level that changes per chunk
  task automatic test_random_traffic(int n_words);
    int done;
    int step;
    int fill_goal;
    int r;
    logic [1:0] k;
    id_t id;
    done = 0;
    step = 0;
    fill_goal = 0;
    while (done < n_words) begin
      if (step % 100 == 0) begin
        fill_goal = $urandom_range(0, SLOTS);
        calm = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 3) k = KIND_SPARE;
      else if (r < 25) k = KIND_TURN;
      else if (members < fill_goal) k = ($urandom_range(0, 9) < 7) ? KIND_JOIN : KIND_ELIM;
      else k = ($urandom_range(0, 9) < 7) ? KIND_ELIM : KIND_JOIN;
      if (k == KIND_ELIM && $urandom_range(0, 9) < 8) id = present_id();
      else if ($urandom_range(0, 1) == 1) id = pool_id();
      else id = id_t'($urandom);
      send_word(k, id);
      done++;
      step++;
    end
    calm = 1'b0;
  endtask

  // result check and random output stalls
  always @(posedge clk) begin : check_reports
    res_t want;
    if (!rst && out_valid && out_ready) begin
      words_out++;
      if (ring_reports.size() == 0) begin
        $error("report with nothing expected: status %0d member %0h count %0d",
               status, current_member, member_count);
        err_cnt++;
      end else begin
        want = ring_reports.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          err_cnt++;
        end
        if (current_valid !== want.cur_valid) begin
          $error("current_valid: expected %0d, got %0d", want.cur_valid, current_valid);
          err_cnt++;
        end
        if (current_member !== want.cur_id) begin
          $error("current_member: expected %0h, got %0h", want.cur_id, current_member);
          err_cnt++;
        end
        if (member_count !== want.count) begin
          $error("member_count: expected %0d, got %0d", want.count, member_count);
          err_cnt++;
        end
        status_seen[want.status]++;
        if (want.count == SLOTS_CNT) full_ring_seen++;
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      hold_left = gap_len();
    end
  end

  // hang detection
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no word moved for %0d cycles", STALL_LIMIT);
        $display("[round_robin_ring_with_removal] ERROR");
        $finish;
      end
    end
  end

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      ring_id[s] = '0;
      ring_link[s] = '0;
      ring_busy[s] = 1'b0;
    end
    head_p = '0;
    tail_p = '0;
    turn_p = '0;
    members = '0;
    for (int s = 0; s < 4; s++) status_seen[s] = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_ring();
    test_head_tail_turn();
    test_full_store();
    test_random_traffic(1907);
    in_valid <= 1'b0;

    // let every report come back, then settle
    while (ring_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("words sent %0d, reports checked %0d, errors %0d",
             words_in, words_out, err_cnt);
    $display("status ok/empty/not found/full: %0d/%0d/%0d/%0d, full ring seen %0d times",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_NOT_FOUND],
             status_seen[ST_FULL], full_ring_seen);
    if (err_cnt == 0) begin
      $display("[round_robin_ring_with_removal] OK");
    end else begin
      $display("[round_robin_ring_with_removal] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/rrr_pkg.sv
rtl/core/rrr_ram.sv
rtl/core/rrr_free_pick.sv
rtl/core/rrr_engine.sv
rtl/core/round_robin_ring_with_removal.sv
rtl/core/rrr_checker.sv
dv/round_robin_ring_with_removal_tb.sv
